>>> rtl/nvmecs_pkg.sv
// Shared types, constants and helpers for the NVMe I/O command splitter.
// Used by nvmecs_ctrl, nvmecs_dp and nvme_io_command_splitter_top.
package nvmecs_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int DB_W        = 6;

  // Page and split limits
  localparam logic [63:0] PAGE_BYTES = 64'd4096;
  localparam int          CID_W      = 16;

  // Stream widths
  localparam int S_DATA_W = 176;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 240;
  localparam int M_USER_W = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS = 2'd2;

  // NVMe opcodes placed in the submission entry
  localparam logic [7:0] NVME_OP_FLUSH = 8'h00;
  localparam logic [7:0] NVME_OP_WRITE = 8'h01;
  localparam logic [7:0] NVME_OP_READ  = 8'h02;

  // Input item opcodes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CQE   = 2'd3
  } in_op_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ENTRY    = 3'd0,
    KIND_REJECT   = 3'd1,
    KIND_CPL_OK   = 3'd2,
    KIND_NOT_YET  = 3'd3,
    KIND_CPL_ERR  = 3'd4
  } kind_t;

  // How the latched item is worked off
  typedef enum logic [1:0] {
    MODE_CQE    = 2'd0,
    MODE_REJECT = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_SPLIT  = 2'd3
  } mode_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_valid;
    logic step_last;
  } dp_status_t;

  // Advance a queue index with wrap at the queue depth
  function automatic logic [QIDX_W-1:0] idx_inc(input logic [QIDX_W-1:0] idx);
    logic [QIDX_W-1:0] r;
    if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + 1'b1;
    end
    return r;
  endfunction

  // Low doorbell bits of a queue index
  function automatic logic [DB_W-1:0] doorbell(input logic [QIDX_W-1:0] idx);
    logic [DB_W+QIDX_W-1:0] wide;
    wide = {{DB_W{1'b0}}, idx};
    return wide[DB_W-1:0];
  endfunction

endpackage

>>> rtl/nvmecs_ctrl.sv
// Controller for the NVMe I/O command splitter: item intake and result pacing.
// Depends on nvmecs_pkg; drives nvmecs_dp through ctrl_cmd_t.
module nvmecs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic                   m_tready,
  input  nvmecs_pkg::dp_status_t status,
  output nvmecs_pkg::ctrl_cmd_t  cmd
);

  nvmecs_pkg::state_t state;
  nvmecs_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nvmecs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    case (state)
      nvmecs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = nvmecs_pkg::ST_RUN;
        end
      end
      nvmecs_pkg::ST_RUN: begin
        // produce one result whenever the output register can take it
        cmd.step = !status.out_valid || m_tready;
        if (cmd.step && status.step_last) begin
          state_next = nvmecs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nvmecs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/nvmecs_dp.sv
// Datapath for the NVMe I/O command splitter: config, queue state, split
// arithmetic and the output register. Depends on nvmecs_pkg.
module nvmecs_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nvmecs_pkg::ctrl_cmd_t                cmd,
  output nvmecs_pkg::dp_status_t               status,
  input  logic [nvmecs_pkg::S_DATA_W-1:0]      s_tdata,
  input  logic [nvmecs_pkg::S_USER_W-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [nvmecs_pkg::M_DATA_W-1:0]      m_tdata,
  output logic [nvmecs_pkg::M_USER_W-1:0]      m_tuser,
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  input  logic [nvmecs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nvmecs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers
  logic       enabled;
  logic [3:0] block_size_log2;
  logic [8:0] max_blocks;

  // Queue state
  logic [nvmecs_pkg::QIDX_W-1:0] sq_tail;
  logic [nvmecs_pkg::QIDX_W-1:0] cq_head;
  logic                          cq_phase;
  logic [nvmecs_pkg::CID_W-1:0]  next_cid;

  // Latched item
  nvmecs_pkg::mode_t mode;
  logic              is_read;
  logic [63:0]       lba;
  logic [63:0]       buf_addr;
  logic [8:0]        remain;
  logic [15:0]       cqe_status;

  // Input fields
  logic [1:0]  in_op;
  logic [63:0] in_lba;
  logic [15:0] in_count;
  logic [63:0] in_buf;
  logic [15:0] in_status;

  assign in_op     = s_tuser;
  assign in_lba    = s_tdata[63:0];
  assign in_count  = s_tdata[79:64];
  assign in_buf    = s_tdata[143:80];
  assign in_status = s_tdata[159:144];

  // Clamped block size as a code 0..3 for 512..4096 bytes
  logic [1:0] bsl_code;
  always_comb begin
    if (block_size_log2 < 4'd9) begin
      bsl_code = 2'd0;
    end else if (block_size_log2 > 4'd12) begin
      bsl_code = 2'd3;
    end else begin
      bsl_code = 2'(block_size_log2 - 4'd9);
    end
  end

  // Blocks per entry, blocks per page and most blocks per request
  logic [4:0] chunk;
  logic [3:0] half_chunk;
  logic [8:0] split_limit;
  assign chunk       = 5'd16 >> bsl_code;
  assign half_chunk  = 4'd8 >> bsl_code;
  assign split_limit = 9'd256 >> bsl_code;

  // Classify an incoming item
  nvmecs_pkg::mode_t mode_in;
  always_comb begin
    if (in_op == nvmecs_pkg::OP_CQE) begin
      mode_in = nvmecs_pkg::MODE_CQE;
    end else if (!enabled) begin
      mode_in = nvmecs_pkg::MODE_REJECT;
    end else if (in_op == nvmecs_pkg::OP_FLUSH) begin
      mode_in = nvmecs_pkg::MODE_FLUSH;
    end else if (in_count == 16'd0 || in_count > {7'd0, max_blocks} ||
                 in_count > {7'd0, split_limit}) begin
      mode_in = nvmecs_pkg::MODE_REJECT;
    end else begin
      mode_in = nvmecs_pkg::MODE_SPLIT;
    end
  end

  // Split step: size of this entry and the advance
  logic [4:0]  entry_blocks;
  logic [16:0] this_bytes;
  logic        two_pages;
  assign entry_blocks = (remain > {4'd0, chunk}) ? chunk : remain[4:0];
  assign this_bytes   = {12'd0, entry_blocks} << ({2'd0, bsl_code} + 4'd9);
  assign two_pages    = entry_blocks > {1'b0, half_chunk};

  // Result of one step
  nvmecs_pkg::kind_t             res_kind;
  logic [7:0]                    res_opc;
  logic [15:0]                   res_cid;
  logic [63:0]                   res_lba;
  logic [7:0]                    res_bm1;
  logic [63:0]                   res_p1;
  logic [63:0]                   res_p2;
  logic                          res_last;
  logic [nvmecs_pkg::QIDX_W-1:0] sq_tail_next;
  logic [nvmecs_pkg::QIDX_W-1:0] cq_head_next;
  logic                          cq_phase_next;
  logic [nvmecs_pkg::CID_W-1:0]  next_cid_next;
  logic [nvmecs_pkg::QIDX_W-1:0] head_inc;

  assign head_inc = nvmecs_pkg::idx_inc(cq_head);

  always_comb begin
    res_kind      = nvmecs_pkg::KIND_REJECT;
    res_opc       = nvmecs_pkg::NVME_OP_FLUSH;
    res_cid       = '0;
    res_lba       = '0;
    res_bm1       = '0;
    res_p1        = '0;
    res_p2        = '0;
    res_last      = 1'b1;
    sq_tail_next  = sq_tail;
    cq_head_next  = cq_head;
    cq_phase_next = cq_phase;
    next_cid_next = next_cid;
    case (mode)
      nvmecs_pkg::MODE_CQE: begin
        if (cqe_status[0] != cq_phase) begin
          res_kind = nvmecs_pkg::KIND_NOT_YET;
        end else begin
          cq_head_next = head_inc;
          if (head_inc == '0) begin
            cq_phase_next = ~cq_phase;
          end
          res_kind = (cqe_status[15:1] == 15'd0) ? nvmecs_pkg::KIND_CPL_OK
                                                 : nvmecs_pkg::KIND_CPL_ERR;
        end
      end
      nvmecs_pkg::MODE_FLUSH: begin
        res_kind      = nvmecs_pkg::KIND_ENTRY;
        res_cid       = next_cid;
        next_cid_next = next_cid + 1'b1;
        sq_tail_next  = nvmecs_pkg::idx_inc(sq_tail);
      end
      nvmecs_pkg::MODE_SPLIT: begin
        res_kind      = nvmecs_pkg::KIND_ENTRY;
        res_opc       = is_read ? nvmecs_pkg::NVME_OP_READ : nvmecs_pkg::NVME_OP_WRITE;
        res_cid       = next_cid;
        res_lba       = lba;
        res_bm1       = {3'd0, entry_blocks - 5'd1};
        res_p1        = buf_addr;
        res_p2        = two_pages ? (buf_addr + nvmecs_pkg::PAGE_BYTES) : 64'd0;
        res_last      = remain <= {4'd0, chunk};
        next_cid_next = next_cid + 1'b1;
        sq_tail_next  = nvmecs_pkg::idx_inc(sq_tail);
      end
      default: begin
        res_kind = nvmecs_pkg::KIND_REJECT;
      end
    endcase
  end

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b0;
      block_size_log2 <= 4'd9;
      max_blocks      <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        nvmecs_pkg::CFG_ENABLED:    enabled         <= cfg_data[0];
        nvmecs_pkg::CFG_BLOCK_LOG2: block_size_log2 <= cfg_data[3:0];
        nvmecs_pkg::CFG_MAX_BLOCKS: max_blocks      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Queue state advances on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_tail  <= '0;
      cq_head  <= '0;
      cq_phase <= 1'b1;
      next_cid <= '0;
    end else if (cmd.step) begin
      sq_tail  <= sq_tail_next;
      cq_head  <= cq_head_next;
      cq_phase <= cq_phase_next;
      next_cid <= next_cid_next;
    end
  end

  // Latch the item, then walk it down one entry per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode       <= mode_in;
      is_read    <= (in_op == nvmecs_pkg::OP_READ);
      lba        <= in_lba;
      buf_addr   <= in_buf;
      remain     <= in_count[8:0];
      cqe_status <= in_status;
    end else if (cmd.step) begin
      lba      <= lba + {59'd0, entry_blocks};
      buf_addr <= buf_addr + {47'd0, this_bytes};
      remain   <= remain - {4'd0, entry_blocks};
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      m_tuser <= res_kind;
      m_tlast <= res_last;
      m_tdata <= {4'd0,
                  nvmecs_pkg::doorbell(cq_head_next),
                  nvmecs_pkg::doorbell(sq_tail_next),
                  res_p2, res_p1, res_bm1, res_lba, res_cid, res_opc};
    end
  end

  assign status.out_valid = m_tvalid;
  assign status.step_last = res_last;

endmodule

>>> rtl/nvme_io_command_splitter_top.sv
// Top level of the NVMe I/O command splitter: controller plus datapath.
// Depends on nvmecs_pkg, nvmecs_ctrl and nvmecs_dp.
//
// Usage: requests, flushes and observed completion entries arrive on the
// s_ stream (s_tuser selects the kind of item). Each one yields one or more
// results on the m_ stream; m_tlast marks the final result of an item and
// m_tuser gives its kind. Read and write requests are split into submission
// entries of at most two 4 KiB pages each; each entry takes the next
// command id and advances the submission tail shown as sq_doorbell.
// Configuration is written on the cfg_ channel, which is always ready; the user
// must write it only while no item is in progress, which the block does not enforce.
// Timing: an item is taken in ST_IDLE, then one result per cycle goes into the
// output register whenever m_tready does not hold it. The next item is taken
// while the last result still waits in the output register. A stalled
// m_tready holds the output register and pauses the split walk.
// Reset (rst, synchronous) empties the output, zeroes tail, head and command
// id, sets the expected phase to one and returns the configuration to
// disabled, 512-byte blocks and 256 blocks per request.
module nvme_io_command_splitter_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // start_lba[63:0], block_count[79:64], buffer_address[143:80],
  // cqe_status[159:144], cqe_cid[175:160]
  input  logic [nvmecs_pkg::S_DATA_W-1:0]   s_tdata,
  // opcode[1:0]
  input  logic [nvmecs_pkg::S_USER_W-1:0]   s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // sq_opcode[7:0], command_id[23:8], entry_lba[87:24], blocks_minus_one[95:88],
  // prp_first[159:96], prp_second[223:160], sq_doorbell[229:224],
  // cq_doorbell[235:230], zero pad[239:236]
  output logic [nvmecs_pkg::M_DATA_W-1:0]   m_tdata,
  // kind[2:0]
  output logic [nvmecs_pkg::M_USER_W-1:0]   m_tuser,
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nvmecs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nvmecs_pkg::CFG_DATA_W-1:0] cfg_data
);

  nvmecs_pkg::ctrl_cmd_t  cmd;
  nvmecs_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  nvmecs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  nvmecs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // A step never overwrites a result that is still held
  assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (!m_tvalid || m_tready))
    else $error("step while output register held");

  // An accepted item closes the intake until its results are produced
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("intake open during item");

  // The final result of an item reopens the intake
  assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.step_last) |=> (s_tready && m_tvalid && m_tlast))
    else $error("intake not reopened after last result");

  // Loading and stepping never coincide
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.step))
    else $error("load and step together");

endmodule
